// ===== design/mip_layer_offset_calc_top_macros.svh =====
`ifndef MIP_LAYER_OFFSET_CALC_TOP_MACROS_SVH
`define MIP_LAYER_OFFSET_CALC_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define MLO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication
`define MLO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `MLO_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== design/mlo_pkg.sv =====
package mlo_pkg;

    localparam int MAX_MIPS   = 16;
    localparam int CUBE_FACES = 6;
    localparam int BLOCK_MIN  = 4;
    localparam int LVL_W      = (MAX_MIPS > 1) ? $clog2(MAX_MIPS) : 1;
    localparam int STEP_W     = 5;
    localparam int ACC_W      = 33;
    localparam int OPB_W      = 16;

    // register indexes
    typedef enum logic [2:0] {
        CFG_BASE_W   = 3'd0,
        CFG_BASE_H   = 3'd1,
        CFG_MIPS     = 3'd2,
        CFG_FRAMES   = 3'd3,
        CFG_SLICES   = 3'd4,
        CFG_CUBE     = 3'd5,
        CFG_BC       = 3'd6,
        CFG_THB      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] base_width;
        logic [15:0] base_height;
        logic [4:0]  mip_count;
        logic [15:0] frame_count;
        logic [15:0] slice_count;
        logic        cube_mode;
        logic        block_compressed;
        logic [5:0]  texel_half_bytes;
    } t_cfg;

    // multiplier operand sources
    typedef enum logic [2:0] {A_ONE, A_ACC, A_X1, A_X2, A_FF} t_asel;
    typedef enum logic [3:0] {
        B_ZERO, B_THB, B_SLICES, B_FACES, B_FRAMES,
        B_SWM, B_SHM, B_SWL, B_SHL, B_FRAME, B_FACE, B_SLICE
    } t_bsel;
    typedef enum logic [2:0] {SV_NONE, SV_X1, SV_X2, SV_FF, SV_RES} t_save;
    typedef enum logic [1:0] {J_NONE, J_ALWAYS, J_BAD, J_MIPDONE} t_jmp;

    typedef struct packed {
        logic              mul_en;
        t_asel             a_sel;
        t_bsel             b_sel;
        t_save             save;
        logic              add_term;
        logic              m_dec;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
        logic              fin;
    } t_uop;

    typedef struct packed {
        logic bad;
        logic mip_done;
    } t_dp_status;

    localparam logic [STEP_W-1:0] STEP_LOOP = 5'd5;
    localparam logic [STEP_W-1:0] STEP_TAIL = 5'd7;
    localparam logic [STEP_W-1:0] STEP_DONE = 5'd18;

    localparam t_uop UOP_NOP = '{1'b0, A_ONE, B_ZERO, SV_NONE, 1'b0, 1'b0,
                                 J_NONE, STEP_DONE, 1'b0};

    // mip dimension: base shifted right by level, at least 1
    function automatic logic [15:0] mip_dim(input logic [15:0] base,
                                            input logic [LVL_W-1:0] lvl);
        logic [15:0] d;
        d = base >> lvl;
        return (d == 16'd0) ? 16'd1 : d;
    endfunction

    // dimension as stored, padded for block formats
    function automatic logic [15:0] stored_dim(input logic [15:0] d, input logic bc);
        return (bc && (d < 16'(BLOCK_MIN))) ? 16'(BLOCK_MIN) : d;
    endfunction

    // control store
    function automatic t_uop mlo_uop(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            5'd0:  u = '{1'b1, A_ONE, B_THB,    SV_NONE, 1'b0, 1'b0, J_BAD, STEP_DONE, 1'b0};
            5'd1:  u = '{1'b1, A_ACC, B_SLICES, SV_NONE, 1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd2:  u = '{1'b1, A_ACC, B_FACES,  SV_X1,   1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd3:  u = '{1'b1, A_ACC, B_FRAMES, SV_X2,   1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd4:  u = '{1'b1, A_ACC, B_ZERO,   SV_FF,   1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd5:  u = '{1'b1, A_FF,  B_SWM,    SV_NONE, 1'b1, 1'b0, J_MIPDONE, STEP_TAIL,
                         1'b0};
            5'd6:  u = '{1'b1, A_ACC, B_SHM,    SV_NONE, 1'b0, 1'b1, J_ALWAYS, STEP_LOOP,
                         1'b0};
            5'd7:  u = '{1'b1, A_X2,  B_SWL,    SV_NONE, 1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd8:  u = '{1'b1, A_ACC, B_SHL,    SV_NONE, 1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd9:  u = '{1'b1, A_ACC, B_FRAME,  SV_NONE, 1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd10: u = '{1'b1, A_X1,  B_SWL,    SV_NONE, 1'b1, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd11: u = '{1'b1, A_ACC, B_SHL,    SV_NONE, 1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd12: u = '{1'b1, A_ACC, B_FACE,   SV_NONE, 1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd13: u = '{1'b1, A_ONE, B_SWL,    SV_NONE, 1'b1, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd14: u = '{1'b1, A_ACC, B_SHL,    SV_NONE, 1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd15: u = '{1'b1, A_ACC, B_THB,    SV_RES,  1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd16: u = '{1'b1, A_ACC, B_SLICE,  SV_NONE, 1'b0, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd17: u = '{1'b0, A_ONE, B_ZERO,   SV_NONE, 1'b1, 1'b0, J_NONE, STEP_DONE, 1'b0};
            5'd18: u = '{1'b0, A_ONE, B_ZERO,   SV_NONE, 1'b0, 1'b0, J_NONE, STEP_DONE, 1'b1};
            default: u = '{1'b0, A_ONE, B_ZERO, SV_NONE, 1'b0, 1'b0, J_ALWAYS, STEP_DONE,
                           1'b0};
        endcase
        return u;
    endfunction

endpackage

// ===== design/mlo_datapath.sv =====
module mlo_datapath (
    input  logic               i_clk,
    input  logic               i_start,
    input  logic               i_run,
    input  mlo_pkg::t_uop      i_uop,
    input  mlo_pkg::t_cfg      i_cfg,
    input  logic [7:0]         i_mip_level,
    input  logic [15:0]        i_frame_index,
    input  logic [7:0]         i_face_index,
    input  logic [15:0]        i_slice_index,
    output mlo_pkg::t_dp_status o_status,
    output logic [31:0]        o_byte_offset,
    output logic [15:0]        o_mip_width,
    output logic [15:0]        o_mip_height,
    output logic [31:0]        o_pixel_count
);
    import mlo_pkg::*;

    logic [7:0]       r_level;
    logic [15:0]      r_frame;
    logic [7:0]       r_face;
    logic [15:0]      r_slice;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_x1;
    logic [ACC_W-1:0] r_x2;
    logic [ACC_W-1:0] r_ff;
    logic [ACC_W-1:0] r_res;
    logic [31:0]      r_offset;
    logic [LVL_W-1:0] r_m;

    logic [4:0]       mips;
    logic [15:0]      frames;
    logic [15:0]      slices;
    logic [2:0]       faces;
    logic [LVL_W-1:0] lvl;
    logic [LVL_W-1:0] m_init;
    logic [15:0]      w_l, h_l, sw_l, sh_l, sw_m, sh_m;
    logic [ACC_W-1:0] opa;
    logic [OPB_W-1:0] opb;
    logic [ACC_W+OPB_W-1:0] prod;
    logic             bad;

    // effective counts
    always_comb begin
        if (i_cfg.mip_count == 5'd0) begin
            mips = 5'd1;
        end else if (i_cfg.mip_count > 5'(MAX_MIPS)) begin
            mips = 5'(MAX_MIPS);
        end else begin
            mips = i_cfg.mip_count;
        end
        frames = (i_cfg.frame_count == 16'd0) ? 16'd1 : i_cfg.frame_count;
        slices = (i_cfg.slice_count == 16'd0) ? 16'd1 : i_cfg.slice_count;
        faces  = i_cfg.cube_mode ? 3'(CUBE_FACES) : 3'd1;
    end

    assign m_init = LVL_W'(mips - 5'd1);
    assign lvl    = r_level[LVL_W-1:0];

    // range check on the captured request
    assign bad = (r_level >= 8'(mips)) || (r_frame >= frames) ||
                 (r_face >= 8'(faces)) || (r_slice >= slices);

    // mip sizes at the requested level and at the loop level
    assign w_l  = mip_dim(i_cfg.base_width, lvl);
    assign h_l  = mip_dim(i_cfg.base_height, lvl);
    assign sw_l = stored_dim(w_l, i_cfg.block_compressed);
    assign sh_l = stored_dim(h_l, i_cfg.block_compressed);
    assign sw_m = stored_dim(mip_dim(i_cfg.base_width, r_m), i_cfg.block_compressed);
    assign sh_m = stored_dim(mip_dim(i_cfg.base_height, r_m), i_cfg.block_compressed);

    // operand select
    always_comb begin
        case (i_uop.a_sel)
            A_ONE:   opa = ACC_W'(1);
            A_ACC:   opa = r_acc;
            A_X1:    opa = r_x1;
            A_X2:    opa = r_x2;
            A_FF:    opa = r_ff;
            default: opa = '0;
        endcase
        case (i_uop.b_sel)
            B_ZERO:   opb = '0;
            B_THB:    opb = OPB_W'(i_cfg.texel_half_bytes);
            B_SLICES: opb = slices;
            B_FACES:  opb = OPB_W'(faces);
            B_FRAMES: opb = frames;
            B_SWM:    opb = sw_m;
            B_SHM:    opb = sh_m;
            B_SWL:    opb = sw_l;
            B_SHL:    opb = sh_l;
            B_FRAME:  opb = r_frame;
            B_FACE:   opb = OPB_W'(r_face);
            B_SLICE:  opb = r_slice;
            default:  opb = '0;
        endcase
    end

    // shared multiplier, kept modulo 2^33
    assign prod = opa * opb;

    // request capture and datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_level  <= i_mip_level;
            r_frame  <= i_frame_index;
            r_face   <= i_face_index;
            r_slice  <= i_slice_index;
            r_offset <= '0;
            r_m      <= m_init;
        end else if (i_run) begin
            if (i_uop.mul_en) begin
                r_acc <= prod[ACC_W-1:0];
            end
            case (i_uop.save)
                SV_X1:   r_x1  <= r_acc;
                SV_X2:   r_x2  <= r_acc;
                SV_FF:   r_ff  <= r_acc;
                SV_RES:  r_res <= r_acc;
                default: ;
            endcase
            // floor to whole bytes, sum wraps at 32 bits
            if (i_uop.add_term) begin
                r_offset <= r_offset + r_acc[ACC_W-1:1];
            end
            if (i_uop.m_dec) begin
                r_m <= r_m - 1'b1;
            end
        end
    end

    assign o_status.bad      = bad;
    assign o_status.mip_done = (r_m <= lvl);

    // result fields, zero on a bad request
    assign o_byte_offset = bad ? 32'd0 : r_offset;
    assign o_mip_width   = bad ? 16'd0 : w_l;
    assign o_mip_height  = bad ? 16'd0 : h_l;
    assign o_pixel_count = bad ? 32'd0 : r_res[31:0];

endmodule

// ===== design/mip_layer_offset_calc_top.sv =====
// Mip image locator. Each request (mip level, frame, cube face, depth slice)
// returns the byte offset of that image in the texture's data block, the
// mip's width and height, and its padded pixel count; out-of-range requests
// return the error flag with all other fields zero. A good request runs one
// microcode loop pass per smaller mip stored ahead of it (mip count - 1 -
// level); a bad request goes straight to the result after its range check.
// The single shared 33x16 multiplier yields one product per control step of
// the microcode. One request is in flight at a time; a new one is taken as
// soon as the previous result sits in the output register. The user must
// write registers through the write port only while no request is in flight;
// the block itself does not enforce this.
module mip_layer_offset_calc_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_mip_level,
    input  logic [15:0] i_frame_index,
    input  logic [7:0]  i_face_index,
    input  logic [15:0] i_slice_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_bad_request,
    output logic [31:0] o_byte_offset,
    output logic [15:0] o_mip_width,
    output logic [15:0] o_mip_height,
    output logic [31:0] o_pixel_count,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    import mlo_pkg::*;

    t_cfg              r_cfg;
    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              r_bad;
    logic [31:0]       r_byte_offset;
    logic [15:0]       r_mip_width;
    logic [15:0]       r_mip_height;
    logic [31:0]       r_pixel_count;

    t_uop       uop;
    t_dp_status status;
    logic       start;
    logic       load_out;
    logic       taken;
    logic [31:0] dp_offset;
    logic [15:0] dp_width;
    logic [15:0] dp_height;
    logic [31:0] dp_pixels;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_width       <= 16'd1;
            r_cfg.base_height      <= 16'd1;
            r_cfg.mip_count        <= 5'd1;
            r_cfg.frame_count      <= 16'd1;
            r_cfg.slice_count      <= 16'd1;
            r_cfg.cube_mode        <= 1'b0;
            r_cfg.block_compressed <= 1'b0;
            r_cfg.texel_half_bytes <= 6'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_W: r_cfg.base_width       <= i_cfg_wdata;
                CFG_BASE_H: r_cfg.base_height      <= i_cfg_wdata;
                CFG_MIPS:   r_cfg.mip_count        <= i_cfg_wdata[4:0];
                CFG_FRAMES: r_cfg.frame_count      <= i_cfg_wdata;
                CFG_SLICES: r_cfg.slice_count      <= i_cfg_wdata;
                CFG_CUBE:   r_cfg.cube_mode        <= i_cfg_wdata[0];
                CFG_BC:     r_cfg.block_compressed <= i_cfg_wdata[0];
                CFG_THB:    r_cfg.texel_half_bytes <= i_cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = !r_busy;
    assign start      = i_in_valid && !r_busy;
    assign uop        = r_busy ? mlo_uop(r_step) : UOP_NOP;

    // sequencer: step counter, jumps and result hand-off
    always_comb begin
        n_busy      = r_busy;
        n_step      = r_step;
        load_out    = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (uop.jmp)
            J_ALWAYS:  taken = 1'b1;
            J_BAD:     taken = status.bad;
            J_MIPDONE: taken = status.mip_done;
            default:   taken = 1'b0;
        endcase
        if (start) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (r_busy) begin
            if (uop.fin) begin
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_busy      = 1'b0;
                end
            end else begin
                n_step = taken ? uop.target : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_bad         <= status.bad;
            r_byte_offset <= dp_offset;
            r_mip_width   <= dp_width;
            r_mip_height  <= dp_height;
            r_pixel_count <= dp_pixels;
        end
    end

    mlo_datapath u_datapath (
        .i_clk         (i_clk),
        .i_start       (start),
        .i_run         (r_busy),
        .i_uop         (uop),
        .i_cfg         (r_cfg),
        .i_mip_level   (i_mip_level),
        .i_frame_index (i_frame_index),
        .i_face_index  (i_face_index),
        .i_slice_index (i_slice_index),
        .o_status      (status),
        .o_byte_offset (dp_offset),
        .o_mip_width   (dp_width),
        .o_mip_height  (dp_height),
        .o_pixel_count (dp_pixels)
    );

    assign o_out_valid   = r_out_valid;
    assign o_bad_request = r_bad;
    assign o_byte_offset = r_byte_offset;
    assign o_mip_width   = r_mip_width;
    assign o_mip_height  = r_mip_height;
    assign o_pixel_count = r_pixel_count;

endmodule

// ===== design/mlo_checker.sv =====
`include "mip_layer_offset_calc_top_macros.svh"

module mlo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_bad_request,
    input logic [31:0] o_byte_offset,
    input logic [15:0] o_mip_width,
    input logic [15:0] o_mip_height,
    input logic [31:0] o_pixel_count
);

    // a stalled result beat stays offered
    `MLO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // one request in flight: ready drops after an accepted beat
    `MLO_ASSERT_NEXT(a_one_inflight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second request taken while busy")

    // a bad request carries all-zero fields
    `MLO_ASSERT(a_bad_zero, i_clk, i_rst_n, o_out_valid && o_bad_request |-> (o_byte_offset == 32'd0) && (o_mip_width == 16'd0) && (o_mip_height == 16'd0) && (o_pixel_count == 32'd0), "bad request with nonzero fields")

    // a good request has nonzero sizes
    `MLO_ASSERT(a_good_size, i_clk, i_rst_n, o_out_valid && !o_bad_request |-> (o_mip_width != 16'd0) && (o_mip_height != 16'd0) && (o_pixel_count != 32'd0), "good request with zero size")

endmodule

bind mip_layer_offset_calc_top mlo_checker u_mlo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_bad_request (o_bad_request),
    .o_byte_offset (o_byte_offset),
    .o_mip_width   (o_mip_width),
    .o_mip_height  (o_mip_height),
    .o_pixel_count (o_pixel_count)
);
